// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the depth filter RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DCF_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DCF_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/dcf_pkg.sv =====
// ---------------------------------------------------------------------------
// dcf_pkg
// Types and constants shared by the 2x2 depth consistency filter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dcf_pkg;

   localparam int DEPTH_W     = 16;
   localparam int MAX_WIDTH   = 512;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = 10;
   localparam int FWIDTH_W    = 10;
   localparam int FHEIGHT_W   = 10;
   localparam int CMP_W       = COL_W + FWIDTH_W;
   localparam int SUM_W       = DEPTH_W + 2;
   localparam int PROD_W      = SUM_W + 7;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_DEPTH    = 3'd0,
      CSR_MAX_DEPTH    = 3'd1,
      CSR_FILTER_EN    = 3'd2,
      CSR_FRAME_WIDTH  = 3'd3,
      CSR_FRAME_HEIGHT = 3'd4
   } csr_index_type;

   localparam logic [DEPTH_W-1:0]   RST_MIN_DEPTH    = 16'd500;
   localparam logic [DEPTH_W-1:0]   RST_MAX_DEPTH    = 16'd4500;
   localparam logic                 RST_FILTER_EN    = 1'b1;
   localparam logic [FWIDTH_W-1:0]  RST_FRAME_WIDTH  = 10'd512;
   localparam logic [FHEIGHT_W-1:0] RST_FRAME_HEIGHT = 10'd424;

   typedef struct packed {
      logic [DEPTH_W-1:0]   min_depth;
      logic [DEPTH_W-1:0]   max_depth;
      logic                 filter_enable;
      logic [FWIDTH_W-1:0]  frame_width;
      logic [FHEIGHT_W-1:0] frame_height;
   } dcf_cfg_type;

   // one 2x2 window: x0 = pixel, x1 = right, x2 = below, x3 = below right
   typedef struct packed {
      logic [DEPTH_W-1:0] x0;
      logic [DEPTH_W-1:0] x1;
      logic [DEPTH_W-1:0] x2;
      logic [DEPTH_W-1:0] x3;
      logic [SUM_W-1:0]   sum;
      logic               all_in;
      logic               x0_in;
      logic               x1_in;
      logic               range_only;
      logic               has_main;
      logic               has_last;
      logic               pad;
   } dcf_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } dcf_qstat_type;

endpackage

`default_nettype wire

// ===== rtl/core/dcf_req_if.sv =====
// ---------------------------------------------------------------------------
// dcf_req_if
// Input channel: one raw depth word per handshake.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dcf_req_if;
   logic                        valid;
   logic                        ready;
   logic [dcf_pkg::DEPTH_W-1:0] depth_in;

   modport source (output valid, output depth_in, input ready);
   modport sink   (input valid, input depth_in, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dcf_rsp_if.sv =====
// ---------------------------------------------------------------------------
// dcf_rsp_if
// Result channel: one filtered depth word per handshake.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dcf_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [dcf_pkg::DEPTH_W-1:0] depth_out;
   logic                        frame_end;

   modport source (output valid, output depth_out, output frame_end, input ready);
   modport sink   (input valid, input depth_out, input frame_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/depth_2x2_consistency_filter.sv =====
// ---------------------------------------------------------------------------
// depth_2x2_consistency_filter
// Streaming 2x2 depth consistency filter with range check.
//
// req_port carries raw depth words in raster order, one frame of
// frame_height rows followed by one padding row whose words only flush.
// rsp_port returns filtered depth words in raster order, one row and one
// column behind the input; frame_end marks the frame's last pixel. The
// last word of each row yields two results, the first row none.
// csr_* writes min_depth, max_depth, filter_enable, frame_width and
// frame_height by index; write only while the block is idle.
// Throughput: one input word per cycle while the queue is not full; the
// output averages one word per input word, and a 4-entry window queue
// absorbs the extra row-end word. The window that an accepted input word
// completes is written into the queue, then loaded into the output
// register; a row-end window's second word follows its first.
// Reset clears counters and the queue and restores register defaults; the
// row store needs no clearing; req_port.ready is low during reset. When
// rsp_port stalls, the queue fills and req_port.ready drops after four
// queued windows.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module depth_2x2_consistency_filter (
   input  wire logic                             clock,
   input  wire logic                             reset,
   dcf_req_if.sink                               req_port,
   dcf_rsp_if.source                             rsp_port,
   input  wire logic                             csr_we,
   input  wire logic [dcf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [dcf_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   dcf_pkg::dcf_cfg_type   cfg_ff, cfg_in;
   dcf_pkg::dcf_entry_type push_entry;
   dcf_pkg::dcf_entry_type head;
   dcf_pkg::dcf_qstat_type qstat;
   logic                   push;
   logic                   pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (dcf_pkg::csr_index_type'(csr_index))
            dcf_pkg::CSR_MIN_DEPTH:    cfg_in.min_depth     = csr_wdata[dcf_pkg::DEPTH_W-1:0];
            dcf_pkg::CSR_MAX_DEPTH:    cfg_in.max_depth     = csr_wdata[dcf_pkg::DEPTH_W-1:0];
            dcf_pkg::CSR_FILTER_EN:    cfg_in.filter_enable = csr_wdata[0];
            dcf_pkg::CSR_FRAME_WIDTH:  cfg_in.frame_width   = csr_wdata[dcf_pkg::FWIDTH_W-1:0];
            dcf_pkg::CSR_FRAME_HEIGHT: cfg_in.frame_height  = csr_wdata[dcf_pkg::FHEIGHT_W-1:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_depth     <= dcf_pkg::RST_MIN_DEPTH;
         cfg_ff.max_depth     <= dcf_pkg::RST_MAX_DEPTH;
         cfg_ff.filter_enable <= dcf_pkg::RST_FILTER_EN;
         cfg_ff.frame_width   <= dcf_pkg::RST_FRAME_WIDTH;
         cfg_ff.frame_height  <= dcf_pkg::RST_FRAME_HEIGHT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dcf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_port   (req_port),
      .qstat      (qstat),
      .push       (push),
      .push_entry (push_entry)
   );

   dcf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .qstat      (qstat)
   );

   dcf_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .qstat    (qstat),
      .pop      (pop),
      .rsp_port (rsp_port)
   );

endmodule

`default_nettype wire

// ===== rtl/core/dcf_front.sv =====
// ---------------------------------------------------------------------------
// dcf_front
// Accepts depth words, tracks row and column, holds the previous row and
// builds the 2x2 window with range flags and sum for the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dcf_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dcf_pkg::dcf_cfg_type  cfg,
   dcf_req_if.sink                    req_port,
   input  wire dcf_pkg::dcf_qstat_type qstat,
   output logic                       push,
   output dcf_pkg::dcf_entry_type     push_entry
);

   logic [dcf_pkg::DEPTH_W-1:0] row_mem [dcf_pkg::MAX_WIDTH];

   logic [dcf_pkg::COL_W-1:0]   col_ff, col_in;
   logic [dcf_pkg::ROW_W-1:0]   row_ff, row_in;
   logic [dcf_pkg::DEPTH_W-1:0] prev_left_ff, prev_left_in;
   logic [dcf_pkg::DEPTH_W-1:0] cur_left_ff, cur_left_in;
   logic [dcf_pkg::DEPTH_W-1:0] up_ff;

   logic [dcf_pkg::FWIDTH_W-1:0]  w_last;
   logic [dcf_pkg::FHEIGHT_W-1:0] h_eff;
   logic                          last;
   logic                          pad;
   logic                          accept;
   logic [dcf_pkg::DEPTH_W-1:0]   d;

   function automatic logic in_range(input logic [dcf_pkg::DEPTH_W-1:0] v,
                                     input dcf_pkg::dcf_cfg_type c);
      return (v >= c.min_depth) && (v <= c.max_depth);
   endfunction

   assign d              = req_port.depth_in;
   assign req_port.ready = !reset && !qstat.full;
   assign accept         = req_port.valid && req_port.ready;

   always_comb begin
      if (cfg.frame_width < dcf_pkg::FWIDTH_W'(2)) begin
         w_last = dcf_pkg::FWIDTH_W'(1);
      end else if (cfg.frame_width > dcf_pkg::FWIDTH_W'(dcf_pkg::MAX_WIDTH)) begin
         w_last = dcf_pkg::FWIDTH_W'(dcf_pkg::MAX_WIDTH - 1);
      end else begin
         w_last = cfg.frame_width - dcf_pkg::FWIDTH_W'(1);
      end
      h_eff = (cfg.frame_height == '0) ? dcf_pkg::FHEIGHT_W'(1) : cfg.frame_height;
   end

   assign last = dcf_pkg::CMP_W'(col_ff) >= dcf_pkg::CMP_W'(w_last);
   assign pad  = row_ff >= h_eff;

   always_comb begin
      push_entry.x0         = prev_left_ff;
      push_entry.x1         = up_ff;
      push_entry.x2         = cur_left_ff;
      push_entry.x3         = d;
      push_entry.sum        = dcf_pkg::SUM_W'(prev_left_ff) + dcf_pkg::SUM_W'(up_ff)
                            + dcf_pkg::SUM_W'(cur_left_ff) + dcf_pkg::SUM_W'(d);
      push_entry.x0_in      = in_range(prev_left_ff, cfg);
      push_entry.x1_in      = in_range(up_ff, cfg);
      push_entry.all_in     = in_range(prev_left_ff, cfg) && in_range(up_ff, cfg)
                            && in_range(cur_left_ff, cfg) && in_range(d, cfg);
      push_entry.range_only = pad || !cfg.filter_enable;
      push_entry.has_main   = (col_ff != '0);
      push_entry.has_last   = last;
      push_entry.pad        = pad;
      push = accept && (row_ff != '0) && ((col_ff != '0) || last);
   end

   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      prev_left_in = prev_left_ff;
      cur_left_in  = cur_left_ff;
      if (accept) begin
         prev_left_in = up_ff;
         if (!pad) begin
            cur_left_in = d;
         end
         if (last) begin
            col_in = '0;
            row_in = pad ? '0 : row_ff + dcf_pkg::ROW_W'(1);
         end else begin
            col_in = col_ff + dcf_pkg::COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         prev_left_ff <= '0;
         cur_left_ff  <= '0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         prev_left_ff <= prev_left_in;
         cur_left_ff  <= cur_left_in;
      end
   end

   // read ahead at the next column, write the current one
   always_ff @(posedge clock) begin
      if (accept && !pad) begin
         row_mem[col_ff] <= d;
      end
      up_ff <= row_mem[col_in];
   end

   `DCF_ASSERT_NEXT(a_pad_row_wraps, clock, reset, accept && last && pad,
                    row_ff == '0 && col_ff == '0, "padding row did not restart frame")
   `DCF_ASSERT_IMPL(a_push_has_room, clock, reset, push, !qstat.full,
                    "window pushed into full queue")

endmodule

`default_nettype wire

// ===== rtl/core/dcf_queue.sv =====
// ---------------------------------------------------------------------------
// dcf_queue
// Short FIFO of windows between front and back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dcf_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire dcf_pkg::dcf_entry_type push_entry,
   input  wire logic                   pop,
   output dcf_pkg::dcf_entry_type      head,
   output dcf_pkg::dcf_qstat_type      qstat
);

   dcf_pkg::dcf_entry_type       entries_ff [dcf_pkg::QUEUE_DEPTH];
   logic [dcf_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [dcf_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [dcf_pkg::QCNT_W-1:0]   count_ff, count_in;

   assign qstat.full  = (count_ff == dcf_pkg::QCNT_W'(dcf_pkg::QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign head        = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + dcf_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + dcf_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + dcf_pkg::QCNT_W'(1);
         2'b01:   count_in = count_ff - dcf_pkg::QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `DCF_ASSERT_IMPL(a_pop_not_empty, clock, reset, pop, !qstat.empty,
                    "pop from empty queue")

endmodule

`default_nettype wire

// ===== rtl/core/dcf_back.sv =====
// ---------------------------------------------------------------------------
// dcf_back
// Runs the consistency test on queued windows and drives the result
// register; an end-of-row window gives two words.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dcf_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire dcf_pkg::dcf_entry_type head,
   input  wire dcf_pkg::dcf_qstat_type qstat,
   output logic                        pop,
   dcf_rsp_if.source                   rsp_port
);

   logic                        phase_ff, phase_in;
   logic                        out_valid_ff, out_valid_in;
   logic [dcf_pkg::DEPTH_W-1:0] out_depth_ff, out_depth_in;
   logic                        out_end_ff, out_end_in;

   logic                        load;
   logic                        close_all;
   logic [dcf_pkg::DEPTH_W-1:0] main_val;
   logic [dcf_pkg::DEPTH_W-1:0] last_val;

   // 100*|4x - sum| < sum
   function automatic logic close_to_mean(input logic [dcf_pkg::DEPTH_W-1:0] x,
                                          input logic [dcf_pkg::SUM_W-1:0]   s);
      logic signed [dcf_pkg::SUM_W:0] diff;
      logic [dcf_pkg::SUM_W-1:0]      mag;
      logic [dcf_pkg::PROD_W-1:0]     prod;
      diff = $signed({1'b0, x, 2'b00}) - $signed({1'b0, s});
      mag  = diff[dcf_pkg::SUM_W] ? dcf_pkg::SUM_W'(-diff) : diff[dcf_pkg::SUM_W-1:0];
      prod = (dcf_pkg::PROD_W'(mag) << 6) + (dcf_pkg::PROD_W'(mag) << 5)
           + (dcf_pkg::PROD_W'(mag) << 2);
      return prod < dcf_pkg::PROD_W'(s);
   endfunction

   assign close_all = close_to_mean(head.x0, head.sum) && close_to_mean(head.x1, head.sum)
                   && close_to_mean(head.x2, head.sum) && close_to_mean(head.x3, head.sum);

   always_comb begin
      if (head.range_only) begin
         main_val = head.x0_in ? head.x0 : '0;
      end else begin
         main_val = (head.all_in && close_all) ? head.x0 : '0;
      end
      last_val = head.x1_in ? head.x1 : '0;
   end

   assign load = !out_valid_ff || rsp_port.ready;

   always_comb begin
      pop          = 1'b0;
      phase_in     = phase_ff;
      out_valid_in = out_valid_ff && !rsp_port.ready;
      out_depth_in = out_depth_ff;
      out_end_in   = out_end_ff;
      if (load && !qstat.empty) begin
         out_valid_in = 1'b1;
         if (head.has_main && !phase_ff) begin
            out_depth_in = main_val;
            out_end_in   = 1'b0;
            if (head.has_last) begin
               phase_in = 1'b1;
            end else begin
               pop = 1'b1;
            end
         end else begin
            out_depth_in = last_val;
            out_end_in   = head.pad;
            phase_in     = 1'b0;
            pop          = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_depth_ff <= out_depth_in;
      out_end_ff   <= out_end_in;
   end

   assign rsp_port.valid     = out_valid_ff;
   assign rsp_port.depth_out = out_depth_ff;
   assign rsp_port.frame_end = out_end_ff;

   `DCF_ASSERT_IMPL(a_second_word_pending, clock, reset, phase_ff,
                    !qstat.empty && head.has_last, "second word without row-end window")

endmodule

`default_nettype wire
